>>> sv/adc_to_lux_step_reporter_defines.svh
// ============================================================================
// ADC-to-lux step reporter assertion macros
// Shorthand for clocked implication checks that use the clk and rst_n in scope.
// ============================================================================
`ifndef ADC_TO_LUX_STEP_REPORTER_DEFINES_SVH
`define ADC_TO_LUX_STEP_REPORTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATLSR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ATLSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/atlsr_pkg.sv
// ============================================================================
// ADC-to-lux step reporter package
// Curve ROM, field widths, register and mode codes, and the queue word type.
// ============================================================================
package atlsr_pkg;

    localparam int CURVE_POINTS    = 22;
    localparam int ADC_BITS        = 10;
    localparam int LUX_W           = 14;
    localparam int PROD_W          = LUX_W + ADC_BITS;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_TEST_MODE = CFG_INDEX_W'(1);

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_EVERY  = 2'd1;
    localparam logic [1:0] MODE_OFFSET = 2'd2;

    localparam logic [LUX_W-1:0] LUX_MAX      = LUX_W'(11000);
    localparam logic [LUX_W-1:0] TEST_OFFSET  = LUX_W'(200);
    localparam logic [LUX_W-1:0] STEP1_THRESH = LUX_W'(15);
    localparam logic [LUX_W-1:0] STEP2_THRESH = LUX_W'(150);
    localparam logic [LUX_W-1:0] STEP3_THRESH = LUX_W'(1500);

    typedef logic [1:0] step_t;

    // Stored step code meaning that nothing has been reported yet.
    localparam logic [2:0] STEP_NONE = 3'd4;

    localparam logic [LUX_W-1:0] CURVE_LUX [CURVE_POINTS] = '{
        LUX_W'(2),    LUX_W'(5),    LUX_W'(8),    LUX_W'(10),   LUX_W'(12),
        LUX_W'(22),   LUX_W'(30),   LUX_W'(50),   LUX_W'(75),   LUX_W'(110),
        LUX_W'(150),  LUX_W'(170),  LUX_W'(300),  LUX_W'(460),  LUX_W'(1000),
        LUX_W'(1500), LUX_W'(1700), LUX_W'(2000), LUX_W'(2850), LUX_W'(3450),
        LUX_W'(6000), LUX_W'(11000)
    };

    localparam logic [ADC_BITS-1:0] CURVE_ADC [CURVE_POINTS] = '{
        ADC_BITS'(8),   ADC_BITS'(10),  ADC_BITS'(45),  ADC_BITS'(69),
        ADC_BITS'(79),  ADC_BITS'(102), ADC_BITS'(159), ADC_BITS'(196),
        ADC_BITS'(200), ADC_BITS'(245), ADC_BITS'(295), ADC_BITS'(307),
        ADC_BITS'(326), ADC_BITS'(378), ADC_BITS'(463), ADC_BITS'(500),
        ADC_BITS'(515), ADC_BITS'(526), ADC_BITS'(561), ADC_BITS'(570),
        ADC_BITS'(603), ADC_BITS'(648)
    };

    // One interpolation job: lux = base + rise * offset / run, or full scale.
    typedef struct packed {
        logic                sat;
        logic [LUX_W-1:0]    base;
        logic [LUX_W-1:0]    rise;
        logic [ADC_BITS-1:0] offset;
        logic [ADC_BITS-1:0] run;
    } atlsr_entry_t;

    // A segment whose ADC span does not grow or whose lux falls is never used.
    function automatic logic seg_usable(input int k);
        return (CURVE_ADC[k+1] > CURVE_ADC[k]) && (CURVE_LUX[k+1] >= CURVE_LUX[k]);
    endfunction

    function automatic step_t lux_to_step(input logic [LUX_W-1:0] lux);
        step_t step;
        if (lux < STEP1_THRESH) begin
            step = 2'd0;
        end
        else if (lux < STEP2_THRESH) begin
            step = 2'd1;
        end
        else if (lux < STEP3_THRESH) begin
            step = 2'd2;
        end
        else begin
            step = 2'd3;
        end
        return step;
    endfunction

endpackage

>>> sv/atlsr_front.sv
// ============================================================================
// ADC-to-lux front end
// Takes samples, finds their curve segment and queues an interpolation job.
// ============================================================================
module atlsr_front (
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [atlsr_pkg::ADC_BITS-1:0] adc_sample,
    input  logic                          enable,
    input  logic                          queue_full,
    output logic                          push,
    output atlsr_pkg::atlsr_entry_t       push_entry
);
    import atlsr_pkg::*;

    logic found;

    // A disabled block swallows samples, so it never stalls then.
    assign in_stall = enable && queue_full;
    assign push     = in_valid && enable && !queue_full;

    always_comb
    begin
        push_entry = '0;
        found      = 1'b0;
        if (adc_sample < CURVE_ADC[0]) begin
            push_entry.base   = '0;
            push_entry.rise   = CURVE_LUX[0];
            push_entry.offset = adc_sample;
            push_entry.run    = CURVE_ADC[0];
        end
        else begin
            push_entry.sat = 1'b1;
            for (int k = 0; k < CURVE_POINTS - 1; k++) begin
                if (!found && seg_usable(k) && (adc_sample >= CURVE_ADC[k])
                    && (adc_sample < CURVE_ADC[k+1])) begin
                    found             = 1'b1;
                    push_entry.sat    = 1'b0;
                    push_entry.base   = CURVE_LUX[k];
                    push_entry.rise   = CURVE_LUX[k+1] - CURVE_LUX[k];
                    push_entry.offset = adc_sample - CURVE_ADC[k];
                    push_entry.run    = CURVE_ADC[k+1] - CURVE_ADC[k];
                end
            end
        end
    end

endmodule

>>> sv/atlsr_queue.sv
// ============================================================================
// ADC-to-lux job queue
// Small first-in first-out buffer of interpolation jobs.
// ============================================================================
module atlsr_queue #(
    parameter int DEPTH = atlsr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  atlsr_pkg::atlsr_entry_t push_entry,
    input  logic                    pop,
    output atlsr_pkg::atlsr_entry_t head,
    output logic                    empty,
    output logic                    full
);
    import atlsr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    atlsr_entry_t     slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= advance(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= advance(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> sv/atlsr_back.sv
// ============================================================================
// ADC-to-lux back end
// Multiplies, divides bit by bit, classifies the step and drives the result.
// ============================================================================
module atlsr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  atlsr_pkg::atlsr_entry_t       head,
    input  logic                          empty,
    output logic                          pop,
    input  logic [1:0]                    test_mode,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [atlsr_pkg::LUX_W-1:0]   lux,
    output logic                          report,
    output logic [atlsr_pkg::LUX_W-1:0]   reported_value,
    output atlsr_pkg::step_t              brightness_step
);
    import atlsr_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} state_t;

    state_t              state_reg;
    atlsr_entry_t        ent_reg;
    logic [PROD_W-1:0]   quot_reg;
    logic [ADC_BITS-1:0] rem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [2:0]          last_step_reg;
    logic                out_valid_reg;
    logic [LUX_W-1:0]    lux_reg;
    logic                report_reg;
    logic [LUX_W-1:0]    value_reg;
    step_t               step_reg;

    logic [ADC_BITS:0]   trial;
    logic [ADC_BITS:0]   diff;
    logic                ge;
    logic [PROD_W:0]     sum;
    logic [LUX_W-1:0]    lux_calc;
    step_t               step_calc;
    logic                normal_mode;
    logic                rep_calc;
    logic [LUX_W-1:0]    value_calc;
    logic                out_free;

    assign pop = (state_reg == ST_IDLE) && !empty;

    // One restoring division step per cycle: shift in the next dividend bit.
    assign trial = {rem_reg, quot_reg[PROD_W-1]};
    assign ge    = (trial >= {1'b0, ent_reg.run});
    assign diff  = trial - {1'b0, ent_reg.run};

    assign sum = (PROD_W+1)'(ent_reg.base) + (PROD_W+1)'(quot_reg);

    always_comb
    begin
        if (ent_reg.sat || (sum > (PROD_W+1)'(LUX_MAX))) begin
            lux_calc = LUX_MAX;
        end
        else begin
            lux_calc = sum[LUX_W-1:0];
        end
    end

    assign step_calc   = lux_to_step(lux_calc);
    assign normal_mode = (test_mode != MODE_EVERY) && (test_mode != MODE_OFFSET);

    always_comb
    begin
        priority if (test_mode == MODE_EVERY) begin
            rep_calc   = 1'b1;
            value_calc = lux_calc;
        end
        else if (test_mode == MODE_OFFSET) begin
            rep_calc   = 1'b1;
            value_calc = lux_calc + TEST_OFFSET;
        end
        else if ({1'b0, step_calc} != last_step_reg) begin
            rep_calc   = 1'b1;
            value_calc = lux_calc;
        end
        else begin
            rep_calc   = 1'b0;
            value_calc = '0;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            last_step_reg <= STEP_NONE;
            out_valid_reg <= 1'b0;
        end
        else begin
            // A new result loaded in the finishing state replaces the taken one.
            if (out_valid_reg && !out_stall && (state_reg != ST_DONE)) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!empty) begin
                        ent_reg   <= head;
                        rem_reg   <= '0;
                        cnt_reg   <= CNT_W'(PROD_W - 1);
                        state_reg <= head.sat ? ST_DONE : ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    quot_reg  <= PROD_W'(ent_reg.rise) * PROD_W'(ent_reg.offset);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    quot_reg <= {quot_reg[PROD_W-2:0], ge};
                    rem_reg  <= ge ? diff[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
                    if (cnt_reg == '0) begin
                        state_reg <= ST_DONE;
                    end
                    else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        lux_reg       <= lux_calc;
                        report_reg    <= rep_calc;
                        value_reg     <= value_calc;
                        step_reg      <= step_calc;
                        if (normal_mode && rep_calc) begin
                            last_step_reg <= {1'b0, step_calc};
                        end
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign lux             = lux_reg;
    assign report          = report_reg;
    assign reported_value  = value_reg;
    assign brightness_step = step_reg;

endmodule

>>> sv/adc_to_lux_step_reporter.sv
// ============================================================================
// ADC-to-lux step reporter
// Converts light-sensor ADC words to lux over a 22-point curve and reports
// brightness step changes, or every value in the test modes.
// ============================================================================
//
//  Channel   Direction  Handshake               Payload
//  cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
//  in        in         in_valid / in_stall     adc_sample
//  out       out        out_valid / out_stall   lux, report, reported_value,
//                                               brightness_step
//
// In the back end a word inside the curve is taken from the queue,
// multiplied, put through 24 restoring division steps and finished; a
// word at or above full scale goes from the queue to the finishing state.
// The input stalls only when the job queue of QUEUE_DEPTH words is full;
// while disabled every input word is taken and dropped. The back end waits
// in its finishing state while a previous result is still held.
// Reset is asynchronous and clears the registers, the queue and the stored
// step, so the first normal-mode result after reset always reports.
//
module adc_to_lux_step_reporter #(
    parameter int QUEUE_DEPTH = atlsr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [atlsr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [atlsr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [atlsr_pkg::ADC_BITS-1:0]    adc_sample,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [atlsr_pkg::LUX_W-1:0]       lux,
    output logic                              report,
    output logic [atlsr_pkg::LUX_W-1:0]       reported_value,
    output logic [1:0]                        brightness_step
);
    import atlsr_pkg::*;

    logic         enable_reg;
    logic [1:0]   test_mode_reg;
    logic         queue_full;
    logic         queue_empty;
    logic         push;
    logic         pop;
    atlsr_entry_t push_entry;
    atlsr_entry_t head;

    // Register writes are always taken; indexes past the list are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            enable_reg    <= 1'b0;
            test_mode_reg <= MODE_NORMAL;
        end
        else if (cfg_valid) begin
            if (cfg_index == REG_ENABLE) begin
                enable_reg <= cfg_data[0];
            end
            else if (cfg_index == REG_TEST_MODE) begin
                test_mode_reg <= cfg_data[1:0];
            end
        end
    end

    // The front end finds the curve segment in the cycle the word arrives and
    // queues the job, so sampling never waits on the divider directly.
    atlsr_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .adc_sample (adc_sample),
        .enable     (enable_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    atlsr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (queue_empty),
        .full       (queue_full)
    );

    // The back end owns the stored step and the output register.
    atlsr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .empty           (queue_empty),
        .pop             (pop),
        .test_mode       (test_mode_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .lux             (lux),
        .report          (report),
        .reported_value  (reported_value),
        .brightness_step (brightness_step)
    );

endmodule

>>> sv/atlsr_checker.sv
// ============================================================================
// ADC-to-lux step reporter checker
// Port-level checks on the result words, bound to the top level.
// ============================================================================
`include "adc_to_lux_step_reporter_defines.svh"

module atlsr_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [atlsr_pkg::LUX_W-1:0]       lux,
    input logic                              report,
    input logic [atlsr_pkg::LUX_W-1:0]       reported_value,
    input logic [1:0]                        brightness_step
);
    import atlsr_pkg::*;

    `ATLSR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(lux) && $stable(report) && $stable(reported_value) && $stable(brightness_step), "result word changed while stalled")

    `ATLSR_ASSERT_IMPLY(a_lux_range, out_valid, lux <= LUX_MAX, "lux above full scale")

    `ATLSR_ASSERT_IMPLY(a_step_match, out_valid, brightness_step == lux_to_step(lux), "brightness step does not match lux")

    `ATLSR_ASSERT_IMPLY(a_quiet_zero, out_valid && !report, reported_value == '0, "reported value nonzero without a report")

    `ATLSR_ASSERT_IMPLY(a_value_form, out_valid && report && (reported_value != lux), reported_value == lux + TEST_OFFSET, "reported value is neither lux nor lux plus offset")

endmodule

bind adc_to_lux_step_reporter atlsr_checker u_checker (.*);

>>> bench/adc_to_lux_step_reporter_checker.sv
// ============================================================================
// ADC-to-lux step reporter checker
// Watches the register, sample and result channels, predicts each result
// word from its own curve table and step state, and compares field by field.
// ============================================================================
module adc_to_lux_step_reporter_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [atlsr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [atlsr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [atlsr_pkg::ADC_BITS-1:0]    adc_sample,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [atlsr_pkg::LUX_W-1:0]       lux,
    input  logic                              report,
    input  logic [atlsr_pkg::LUX_W-1:0]       reported_value,
    input  logic [1:0]                        brightness_step,
    output int unsigned                       failures,
    output int unsigned                       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import atlsr_pkg::*;

    typedef struct packed {
        logic [LUX_W-1:0] lux;
        logic             report;
        logic [LUX_W-1:0] value;
        step_t            step;
    } lux_word_t;

    int unsigned knee_lux [0:21] = '{
        2, 5, 8, 10, 12, 22, 30, 50, 75, 110, 150,
        170, 300, 460, 1000, 1500, 1700, 2000, 2850, 3450, 6000, 11000
    };
    int unsigned knee_adc [0:21] = '{
        8, 10, 45, 69, 79, 102, 159, 196, 200, 245, 295,
        307, 326, 378, 463, 500, 515, 526, 561, 570, 603, 648
    };

    logic        polling;
    logic [1:0]  mode;
    logic [2:0]  held_step;
    lux_word_t   lux_expected [$];

    initial failures = 0;

    // Piecewise-linear conversion, multiplying before dividing.
    function automatic logic [LUX_W-1:0] adc_lux(input logic [ADC_BITS-1:0] adc);
        int unsigned a;
        int unsigned v;
        a = adc;
        if (a < knee_adc[0]) begin
            return (knee_adc[0] == 0) ? '0 : LUX_W'(knee_lux[0] * a / knee_adc[0]);
        end
        for (int k = 0; k < 21; k++) begin
            if (knee_adc[k+1] > knee_adc[k] && knee_lux[k+1] >= knee_lux[k]
                && a >= knee_adc[k] && a < knee_adc[k+1]) begin
                v = knee_lux[k] + (knee_lux[k+1] - knee_lux[k]) * (a - knee_adc[k])
                    / (knee_adc[k+1] - knee_adc[k]);
                return (v > LUX_MAX) ? LUX_MAX : LUX_W'(v);
            end
        end
        return LUX_MAX;
    endfunction

    function automatic step_t lux_band(input logic [LUX_W-1:0] value);
        if (value < STEP1_THRESH) return 2'd0;
        if (value < STEP2_THRESH) return 2'd1;
        if (value < STEP3_THRESH) return 2'd2;
        return 2'd3;
    endfunction

    task automatic flag(input string what, input int unsigned seen,
                        input int unsigned wanted);
        failures++;
        $display("lux check: %s got %0d expected %0d at %0t", what, seen, wanted, $time);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        lux_word_t want;
        if (!rst_n)
        begin
            polling   = 1'b0;
            mode      = MODE_NORMAL;
            held_step = STEP_NONE;
            lux_expected.delete();
            pending   = 0;
        end
        else
        begin
            // Results first: a sample taken at this same edge cannot be answered yet.
            if (out_valid && !out_stall)
            begin
                if (lux_expected.size() == 0)
                    flag("result word with nothing pending, lux", lux, 0);
                else
                begin
                    want = lux_expected.pop_front();
                    if (lux !== want.lux)
                        flag("lux", lux, want.lux);
                    if (report !== want.report)
                        flag("report", report, want.report);
                    if (reported_value !== want.value)
                        flag("reported_value", reported_value, want.value);
                    if (brightness_step !== want.step)
                        flag("brightness_step", brightness_step, want.step);
                end
            end

            if (in_valid && !in_stall && polling)
            begin
                want.lux    = adc_lux(adc_sample);
                want.step   = lux_band(want.lux);
                want.report = 1'b0;
                want.value  = '0;
                if (mode == MODE_EVERY)
                begin
                    want.report = 1'b1;
                    want.value  = want.lux;
                end
                else if (mode == MODE_OFFSET)
                begin
                    want.report = 1'b1;
                    want.value  = want.lux + TEST_OFFSET;
                end
                else if (held_step != {1'b0, want.step})
                begin
                    // Normal mode, and the spare mode code that behaves like it.
                    want.report = 1'b1;
                    want.value  = want.lux;
                    held_step   = {1'b0, want.step};
                end
                lux_expected.push_back(want);
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ENABLE)
                    polling = cfg_data[0];
                else if (cfg_index == REG_TEST_MODE)
                    mode = cfg_data[1:0];
            end

            pending = lux_expected.size();
        end
    end

endmodule

>>> bench/adc_to_lux_step_reporter_test.sv
// ============================================================================
// ADC-to-lux step reporter testbench
// Drives register writes and ADC sample words with random gaps and result
// stalls; a separate checker predicts and compares every result word.
// ============================================================================
module adc_to_lux_step_reporter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import atlsr_pkg::*;

    // The spare test mode code; the block must treat it as normal mode.
    localparam logic [1:0] MODE_SPARE = 2'd3;
    // An index past the register list; writes to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = CFG_INDEX_W'(15);

    localparam int RANDOM_ITEMS  = 750;
    // Long enough for a word inside the curve to get through, covering the tail.
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 400000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [ADC_BITS-1:0]    adc_sample;
    logic                   out_valid;
    logic                   out_stall;
    logic [LUX_W-1:0]       lux;
    logic                   report;
    logic [LUX_W-1:0]       reported_value;
    logic [1:0]             brightness_step;

    int unsigned failures;
    int unsigned pending;

    // When set, neither side idles, giving one long back-to-back stretch.
    bit          quiet = 1'b0;
    logic        enabled_now;
    int unsigned counted;
    int unsigned cycles;

    // Breakpoints and step edges used to aim the random samples.
    int knee_adc [0:21] = '{
        8, 10, 45, 69, 79, 102, 159, 196, 200, 245, 295,
        307, 326, 378, 463, 500, 515, 526, 561, 570, 603, 648
    };
    int step_edge [0:5] = '{85, 86, 294, 295, 499, 500};

    adc_to_lux_step_reporter DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .adc_sample      (adc_sample),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .lux             (lux),
        .report          (report),
        .reported_value  (reported_value),
        .brightness_step (brightness_step)
    );

    adc_to_lux_step_reporter_checker lux_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .adc_sample      (adc_sample),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .lux             (lux),
        .report          (report),
        .reported_value  (reported_value),
        .brightness_step (brightness_step),
        .failures        (failures),
        .pending         (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The watchdog ends a run that hangs, for instance a result that never comes.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // The result side stalls in about 15 percent of cycles, except in the
    // quiet stretch. It changes only at the falling edge, like every input.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= !quiet && ($urandom_range(0, 99) < 15);
        end
    end

    function automatic bit idle_now();
        return !quiet && ($urandom_range(0, 99) < 15);
    endfunction

    // Random samples: a share spread over the whole range, more inside the
    // curve, some right at breakpoints and step edges, and some drifting
    // slowly from the last one so that normal mode often sees no step change.
    function automatic logic [ADC_BITS-1:0] pick_sample(input logic [ADC_BITS-1:0] prev);
        int unsigned roll;
        int          v;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            v = $urandom_range(0, 1023);
        else if (roll < 55)
            v = $urandom_range(0, 700);
        else if (roll < 75)
            v = knee_adc[5'($urandom_range(0, 21))] + int'($urandom_range(0, 4)) - 2;
        else if (roll < 85)
            v = step_edge[3'($urandom_range(0, 5))] + int'($urandom_range(0, 2)) - 1;
        else
            v = int'(prev) + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return ADC_BITS'(v);
    endfunction

    // Offers one sample word, possibly after a few idle cycles, and holds it
    // until the block takes it. Returns just after the accepting edge.
    task automatic send_sample(input logic [ADC_BITS-1:0] value);
        @(negedge clk);
        while (idle_now())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        adc_sample <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (enabled_now)
            counted++;
    endtask

    // Drops the sample valid, waits until every predicted result word has
    // come back, then lets a disabled or dropped word run out of the block.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (index == REG_ENABLE)
            enabled_now = data[0];
    endtask

    initial
    begin : stimulus
        logic [ADC_BITS-1:0] prev;
        int unsigned         phase;
        int unsigned         length;
        logic                en;
        logic [1:0]          mode;

        // Every input is known from time zero; reset is held, then released at a falling edge.
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        adc_sample  = '0;
        enabled_now = 1'b0;
        counted     = 0;
        prev        = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // After reset polling is off, so these words are taken and dropped.
        send_sample(10'd0);
        send_sample(10'd1023);
        settle();
        // A write past the register list must leave polling off.
        write_register(REG_UNUSED, 8'hFF);
        send_sample(10'd512);
        settle();

        // Normal mode with all upper data bits set: zero, the first knee,
        // each step edge from both sides, full scale and a repeat that must
        // stay silent.
        write_register(REG_ENABLE, 8'hFF);
        write_register(REG_TEST_MODE, 8'hFC);
        send_sample(10'd0);
        send_sample(10'd7);
        send_sample(10'd8);
        send_sample(10'd9);
        send_sample(10'd85);
        send_sample(10'd86);
        send_sample(10'd294);
        send_sample(10'd295);
        send_sample(10'd499);
        send_sample(10'd500);
        send_sample(10'd647);
        send_sample(10'd648);
        send_sample(10'd1023);
        send_sample(10'd1023);
        settle();

        // Report every word, then every word plus the offset.
        write_register(REG_TEST_MODE, {6'd0, MODE_EVERY});
        send_sample(10'd0);
        send_sample(10'd1023);
        settle();
        write_register(REG_TEST_MODE, {6'd0, MODE_OFFSET});
        send_sample(10'd648);
        send_sample(10'd86);
        settle();

        // The spare code acts as normal mode, and the test modes must not
        // have touched the stored step: full scale stays silent, zero reports.
        write_register(REG_TEST_MODE, {6'd0, MODE_SPARE});
        send_sample(10'd1023);
        send_sample(10'd0);
        settle();

        // Random phases, each under one setting. The first few walk through
        // every mode and a disabled stretch; the third has no idling at all.
        phase   = 0;
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            case (phase)
                0: begin en = 1'b1; mode = MODE_NORMAL; end
                1: begin en = 1'b1; mode = MODE_EVERY;  end
                2: begin en = 1'b1; mode = MODE_OFFSET; end
                3: begin en = 1'b1; mode = MODE_SPARE;  end
                4: begin en = 1'b0; mode = MODE_NORMAL; end
                default:
                begin
                    en   = ($urandom_range(0, 9) != 0);
                    mode = 2'($urandom_range(0, 3));
                end
            endcase
            if ($urandom_range(0, 1))
                write_register(CFG_INDEX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));
            write_register(REG_ENABLE,
                           (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1)) | CFG_DATA_W'(en));
            write_register(REG_TEST_MODE,
                           (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(3)) | CFG_DATA_W'(mode));
            quiet  = (phase == 2);
            length = en ? $urandom_range(60, 110) : 20;
            repeat (length)
            begin
                prev = pick_sample(prev);
                send_sample(prev);
            end
            settle();
            quiet = 1'b0;
            phase++;
        end

        if (failures == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
